// File: rtl/tcsl_pkg.sv
package tcsl_pkg;

    localparam int SPEED_W   = 16;
    localparam int TIME_W    = 32;
    localparam int REG_W     = 16;
    localparam int SUM_W     = SPEED_W + 1;
    localparam int NUM_W     = SPEED_W + 13;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0] SLIP_STEPS  = CNT_W'(NUM_W);
    localparam logic [CNT_W-1:0] SCALE_STEPS = CNT_W'(15);

    localparam logic [REG_W-1:0] SCALE_FULL = 16'h8000;
    localparam logic [REG_W-1:0] SLIP_MAX   = 16'hFFFF;
    localparam logic [NUM_W-1:0] SLIP_ONE   = NUM_W'(4096);

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SLIP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TIME   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IDLE    = 3'd3;

    localparam logic [REG_W-1:0] RST_TARGET_SLIP = 16'd819;
    localparam logic [REG_W-1:0] RST_RAMP_TIME   = 16'd500;
    localparam logic [REG_W-1:0] RST_HOLD_TIME   = 16'd50;
    localparam logic [REG_W-1:0] RST_MIN_IDLE    = 16'd168;

    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] divisor;
        logic [SUM_W-1:0] rem_init;
        logic [NUM_W-1:0] num;
        logic [CNT_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } t_div_rsp;

endpackage

// File: rtl/traction_control_slip_limiter_unit.sv
// Traction control slip limiter. Each beat carries four wheel speeds and a
// millisecond time stamp; tuser selects start (arm the controller, full torque)
// or update. An update measures slip as the faster rear wheel over the mean
// front speed minus one (Q4.12, saturated) and returns a Q1.15 torque scale
// that is cut to zero once slip has been held above target for the hold time
// and otherwise ramps back to full over the ramp time. One item is processed
// at a time. An update runs its divisions on a single shared restoring
// divider that produces one quotient bit per cycle (29 steps for the slip
// quotient, 15 for the ramp fraction). The result register lets the next beat
// be accepted while a result waits.
module traction_control_slip_limiter_unit
    import tcsl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // time_stamp, front_left_speed, front_right_speed, rear_left_speed,
    // rear_right_speed
    input  logic [95:0]          s_axis_tdata,
    // func
    input  logic                 s_axis_tuser,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // torque_scale, slip_ratio
    output logic [31:0]          m_axis_tdata,
    // slipping_now, torque_cut
    output logic [1:0]           m_axis_tuser
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SLIP,
        S_EVAL,
        S_HOLD,
        S_DECIDE,
        S_SCALE,
        S_DONE
    } t_state;

    t_state r_state;

    logic [REG_W-1:0]   r_target_slip;
    logic [REG_W-1:0]   r_ramp_time;
    logic [REG_W-1:0]   r_hold_time;
    logic [REG_W-1:0]   r_min_idle;

    logic               r_flag;
    logic [TIME_W-1:0]  r_change_time;
    logic [TIME_W-1:0]  r_ramp_start;

    logic               r_func;
    logic [TIME_W-1:0]  r_ts;
    logic [SPEED_W-1:0] r_fl;
    logic [SPEED_W-1:0] r_fr;
    logic [SPEED_W-1:0] r_rl;
    logic [SPEED_W-1:0] r_rr;

    logic [REG_W-1:0]   r_slip;
    logic [REG_W-1:0]   r_scale;
    logic               r_now;
    logic               r_cut;
    logic [TIME_W-1:0]  r_el;
    logic [TIME_W-1:0]  r_d;

    logic               r_out_valid;
    logic [REG_W-1:0]   r_out_scale;
    logic [REG_W-1:0]   r_out_slip;
    logic               r_out_now;
    logic               r_out_cut;

    t_div_req           r_div_req;
    t_div_rsp           w_div_rsp;

    logic [SUM_W-1:0]   w_sum;
    logic [SPEED_W-1:0] w_rear;
    logic [SUM_W-1:0]   w_idle2;
    logic [NUM_W-1:0]   w_q_off;
    logic               w_cut;
    logic               w_full;
    logic               w_accept;
    logic               w_out_free;

    tcsl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        w_sum      = {1'b0, r_fl} + {1'b0, r_fr};
        w_rear     = (r_rl > r_rr) ? r_rl : r_rr;
        w_idle2    = {r_min_idle, 1'b0};
        w_q_off    = w_div_rsp.quo - SLIP_ONE;
        w_cut      = r_now && !r_el[TIME_W-1] && (r_el >= {16'b0, r_hold_time});
        w_full     = (r_d >= {16'b0, r_ramp_time});
        w_accept   = s_axis_tvalid && s_axis_tready;
        w_out_free = !r_out_valid || m_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_target_slip   <= RST_TARGET_SLIP;
            r_ramp_time     <= RST_RAMP_TIME;
            r_hold_time     <= RST_HOLD_TIME;
            r_min_idle      <= RST_MIN_IDLE;
            r_flag          <= 1'b0;
            r_change_time   <= '0;
            r_ramp_start    <= '0;
            r_out_valid     <= 1'b0;
            r_div_req.start <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TARGET_SLIP: r_target_slip <= i_cfg_data;
                    CFG_RAMP_TIME:   r_ramp_time   <= i_cfg_data;
                    CFG_HOLD_TIME:   r_hold_time   <= i_cfg_data;
                    CFG_MIN_IDLE:    r_min_idle    <= i_cfg_data;
                    default: ;
                endcase
            end

            if (m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func  <= s_axis_tuser;
                        r_ts    <= s_axis_tdata[31:0];
                        r_fl    <= s_axis_tdata[47:32];
                        r_fr    <= s_axis_tdata[63:48];
                        r_rl    <= s_axis_tdata[79:64];
                        r_rr    <= s_axis_tdata[95:80];
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_func == FUNC_START) begin
                        r_flag        <= 1'b0;
                        r_change_time <= r_ts;
                        r_ramp_start  <= r_ts - {16'b0, r_ramp_time};
                        r_scale       <= SCALE_FULL;
                        r_slip        <= '0;
                        r_now         <= 1'b0;
                        r_cut         <= 1'b0;
                        r_state       <= S_DONE;
                    end else if (w_sum < w_idle2) begin
                        r_slip  <= '0;
                        r_state <= S_EVAL;
                    end else if (w_sum == '0) begin
                        r_slip  <= (w_rear == '0) ? '0 : SLIP_MAX;
                        r_state <= S_EVAL;
                    end else begin
                        r_div_req.start    <= 1'b1;
                        r_div_req.divisor  <= w_sum;
                        r_div_req.rem_init <= '0;
                        r_div_req.num      <= {w_rear, 13'b0};
                        r_div_req.steps    <= SLIP_STEPS;
                        r_state            <= S_SLIP;
                    end
                end
                S_SLIP: begin
                    r_div_req.start <= 1'b0;
                    if (w_div_rsp.done) begin
                        if (w_div_rsp.quo <= SLIP_ONE) begin
                            r_slip <= '0;
                        end else if (w_q_off > NUM_W'(SLIP_MAX)) begin
                            r_slip <= SLIP_MAX;
                        end else begin
                            r_slip <= w_q_off[REG_W-1:0];
                        end
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_now  <= (r_slip > r_target_slip);
                    r_flag <= (r_slip > r_target_slip);
                    if ((r_slip > r_target_slip) != r_flag) begin
                        r_change_time <= r_ts;
                    end
                    r_state <= S_HOLD;
                end
                S_HOLD: begin
                    r_el    <= r_ts - r_change_time;
                    r_d     <= r_ts - r_ramp_start;
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_cut <= w_cut;
                    if (w_cut) begin
                        r_scale      <= '0;
                        r_ramp_start <= r_ts;
                        r_state      <= S_DONE;
                    end else if (r_d[TIME_W-1]) begin
                        r_scale <= '0;
                        r_state <= S_DONE;
                    end else if (w_full) begin
                        r_scale <= SCALE_FULL;
                        r_state <= S_DONE;
                    end else begin
                        // d below ramp time, so the remainder starts at d
                        r_div_req.start    <= 1'b1;
                        r_div_req.divisor  <= {1'b0, r_ramp_time};
                        r_div_req.rem_init <= {1'b0, r_d[REG_W-1:0]};
                        r_div_req.num      <= '0;
                        r_div_req.steps    <= SCALE_STEPS;
                        r_state            <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_div_req.start <= 1'b0;
                    if (w_div_rsp.done) begin
                        r_scale <= {1'b0, w_div_rsp.quo[REG_W-2:0]};
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_scale <= r_scale;
                        r_out_slip  <= r_slip;
                        r_out_now   <= r_now;
                        r_out_cut   <= r_cut;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_slip, r_out_scale};
    assign m_axis_tuser  = {r_out_cut, r_out_now};

endmodule

// File: rtl/tcsl_div.sv
module tcsl_div
    import tcsl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [SUM_W-1:0] r_rem;
    logic [SUM_W-1:0] r_div;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [SUM_W:0]   w_trial;
    logic [SUM_W:0]   w_diff;
    logic             w_ge;
    logic [SUM_W-1:0] n_rem;

    // one restoring step: one quotient bit per cycle
    always_comb begin
        w_trial = {r_rem, r_num[NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_rem   = w_ge ? w_diff[SUM_W-1:0] : w_trial[SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == CNT_W'(1));
            if (i_req.start) begin
                r_rem  <= i_req.rem_init;
                r_div  <= i_req.divisor;
                r_num  <= i_req.num;
                r_quo  <= '0;
                r_cnt  <= i_req.steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                r_quo <= {r_quo[NUM_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule
